// File: rtl/rsas_pkg.sv
`default_nettype none
package rsas_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int BND_W   = ADDR_W + 2;
  localparam int VALUE_W = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } rsas_cmd_t;

  typedef struct packed {
    rsas_cmd_t                  cmd;
    logic [ADDR_W-1:0]          entry_index;
    logic signed [VALUE_W-1:0]  entry_value;
    logic signed [VALUE_W-1:0]  target_value;
  } rsas_in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } rsas_out_t;

  typedef struct packed {
    logic              en_a;
    logic              en_b;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rsas_rd_req_t;

  typedef struct packed {
    logic                      en;
    logic [ADDR_W-1:0]         addr;
    logic signed [VALUE_W-1:0] data;
  } rsas_wr_req_t;

  typedef struct packed {
    logic hit;
    logic go_right;
  } rsas_step_t;

endpackage
`default_nettype wire

// File: rtl/rsas_mem.sv
`default_nettype none
module rsas_mem (
  input  wire logic                            clk,
  input  wire rsas_pkg::rsas_wr_req_t          wr,
  input  wire rsas_pkg::rsas_rd_req_t          rd,
  output logic signed [rsas_pkg::VALUE_W-1:0]  rd_data_a,
  output logic signed [rsas_pkg::VALUE_W-1:0]  rd_data_b
);

  logic signed [rsas_pkg::VALUE_W-1:0] mem [rsas_pkg::DEPTH];
  logic signed [rsas_pkg::VALUE_W-1:0] rd_a_r;
  logic signed [rsas_pkg::VALUE_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en_a) begin
      rd_a_r <= mem[rd.addr_a];
    end
    if (rd.en_b) begin
      rd_b_r <= mem[rd.addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule
`default_nettype wire

// File: rtl/rsas_step.sv
`default_nettype none
module rsas_step (
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] v_lo,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] v_mid,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] v_hi,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] target,
  output rsas_pkg::rsas_step_t                     step
);

  logic left_sorted;
  logic in_left;
  logic in_right;

  always_comb begin
    left_sorted   = (v_lo <= v_mid);
    in_left       = (v_lo <= target) && (target <= v_mid);
    in_right      = (v_mid <= target) && (target <= v_hi);
    step.hit      = (v_mid == target);
    step.go_right = left_sorted ? !in_left : in_right;
  end

endmodule
`default_nettype wire

// File: rtl/rsas_ctrl.sv
`default_nettype none
module rsas_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rsas_pkg::LEN_W-1:0]          cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rsas_pkg::rsas_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rsas_pkg::rsas_out_t                      out_data,
  output rsas_pkg::rsas_wr_req_t                   wr,
  output rsas_pkg::rsas_rd_req_t                   rd,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] rd_data_a,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] rd_data_b
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HI   = 3'b010,
    S_DEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [rsas_pkg::LEN_W-1:0]          len_r;
  logic signed [rsas_pkg::BND_W-1:0]   lo_r, lo_nxt;
  logic signed [rsas_pkg::BND_W-1:0]   hi_r, hi_nxt;
  logic signed [rsas_pkg::BND_W-1:0]   mid_r, mid_nxt;
  logic signed [rsas_pkg::VALUE_W-1:0] t_r, t_nxt;
  logic signed [rsas_pkg::VALUE_W-1:0] vl_r, vl_nxt;
  logic                                out_valid_r, out_valid_nxt;
  rsas_pkg::rsas_out_t                 out_data_r, out_data_nxt;

  logic                                accept;
  logic [rsas_pkg::LEN_W-1:0]          n_len;
  logic signed [rsas_pkg::BND_W-1:0]   hi0;
  logic signed [rsas_pkg::BND_W-1:0]   cand_lo, cand_hi;
  logic signed [rsas_pkg::BND_W:0]     mid_sum;
  rsas_pkg::rsas_step_t                step;

  rsas_step u_step (
    .v_lo   (vl_r),
    .v_mid  (rd_data_b),
    .v_hi   (rd_data_a),
    .target (t_r),
    .step   (step)
  );

  always_comb begin
    in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    accept   = in_valid && in_ready;
    n_len    = (len_r > rsas_pkg::LEN_W'(rsas_pkg::DEPTH)) ?
               rsas_pkg::LEN_W'(rsas_pkg::DEPTH) : len_r;
    hi0      = rsas_pkg::BND_W'(n_len) - rsas_pkg::BND_W'(1);

    cand_lo = step.go_right ? (mid_r + rsas_pkg::BND_W'(1)) : lo_r;
    cand_hi = step.go_right ? hi_r : (mid_r - rsas_pkg::BND_W'(1));
    mid_sum = (rsas_pkg::BND_W+1)'(cand_lo) + (rsas_pkg::BND_W+1)'(cand_hi);

    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    t_nxt         = t_r;
    vl_nxt        = vl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    wr.en   = 1'b0;
    wr.addr = in_data.entry_index;
    wr.data = in_data.entry_value;
    rd      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == rsas_pkg::CMD_LOAD) begin
            wr.en = 1'b1;
          end else if (n_len == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = hi0;
            mid_nxt   = hi0 >>> 1;
            t_nxt     = in_data.target_value;
            rd.en_a   = 1'b1;
            rd.en_b   = 1'b1;
            rd.addr_a = '0;
            rd.addr_b = mid_nxt[rsas_pkg::ADDR_W-1:0];
            state_nxt = S_HI;
          end
        end
      end
      S_HI: begin
        vl_nxt    = rd_data_a;
        rd.en_a   = 1'b1;
        rd.addr_a = hi_r[rsas_pkg::ADDR_W-1:0];
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (step.hit) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.position = mid_r[rsas_pkg::ADDR_W-1:0];
          state_nxt             = S_IDLE;
        end else if (cand_lo <= cand_hi) begin
          lo_nxt    = cand_lo;
          hi_nxt    = cand_hi;
          mid_nxt   = rsas_pkg::BND_W'(mid_sum >>> 1);
          rd.en_a   = 1'b1;
          rd.en_b   = 1'b1;
          rd.addr_a = cand_lo[rsas_pkg::ADDR_W-1:0];
          rd.addr_b = mid_nxt[rsas_pkg::ADDR_W-1:0];
          state_nxt = S_HI;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    t_r        <= t_nxt;
    vl_r       <= vl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/rotated_sorted_array_search_unit.sv
`default_nettype none
// Searches a loaded array of signed 32-bit values, an ascending list rotated at some point,
// for a target value and returns a found flag and the matching position (position 0 when
// absent). A load request writes one entry and returns nothing. A search
// request starts the binary search and then runs it probe by probe, at most floor(log2(n)) + 1
// probes for length n; each probe reads the low and middle entries, then the high entry, from
// the two-port entry memory and decides with the shared compare unit. Requests are not taken
// while a search runs. The length register may only be written while no search is in flight.
module rotated_sorted_array_search_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rsas_pkg::LEN_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire rsas_pkg::rsas_in_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rsas_pkg::rsas_out_t               out_data
);

  rsas_pkg::rsas_wr_req_t              wr;
  rsas_pkg::rsas_rd_req_t              rd;
  logic signed [rsas_pkg::VALUE_W-1:0] rd_data_a;
  logic signed [rsas_pkg::VALUE_W-1:0] rd_data_b;

  rsas_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  rsas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr        (wr),
    .rd        (rd),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule
`default_nettype wire

// File: rtl/rsas_checker.sv
`default_nettype none
module rsas_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       cfg_we,
  input wire logic [rsas_pkg::LEN_W-1:0] cfg_wdata,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire rsas_pkg::rsas_in_t         in_data,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire rsas_pkg::rsas_out_t        out_data
);

  logic [rsas_pkg::LEN_W-1:0] len_r;
  logic [rsas_pkg::LEN_W-1:0] n_len;
  logic                       in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  assign n_len  = (len_r > rsas_pkg::LEN_W'(rsas_pkg::DEPTH)) ?
                  rsas_pkg::LEN_W'(rsas_pkg::DEPTH) : len_r;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("miss with non-zero position");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> rsas_pkg::LEN_W'(out_data.position) < n_len)
    else $error("hit position outside the array in use");

  a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.cmd == rsas_pkg::CMD_SEARCH && n_len == '0 |=> out_valid)
    else $error("search of an empty array not answered at once");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.cmd == rsas_pkg::CMD_LOAD && !out_valid |=> !out_valid)
    else $error("load request produced a result");

endmodule

bind rotated_sorted_array_search_unit rsas_checker u_rsas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
